// ----- rtl/ptt_pkg.sv -----
package ptt_pkg;

    localparam int SLOT_IDX_W  = 6;
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_CNT_W  = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_RUN    = 2'd2,
        OP_QUERY  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_ERASE   = 2'd1,
        KIND_FIRED   = 2'd2,
        KIND_TIMEOUT = 2'd3
    } reply_kind_t;

    typedef enum logic [2:0] {
        CELL_IDLE,
        CELL_INSERT,
        CELL_MIN,
        CELL_DUE,
        CELL_ERASE,
        CELL_SHIFT,
        CELL_FIRE
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERASE,
        ST_SHIFT,
        ST_SCAN,
        ST_FIRE,
        ST_OUT
    } state_t;

    typedef struct packed {
        cell_op_t               op;
        logic [SLOT_IDX_W-1:0]  sel;
        logic [63:0]            expiry;
        logic [31:0]            period;
        logic [63:0]            now;
        logic [63:0]            diff;
    } cell_cmd_t;

    typedef struct packed {
        logic                   live;
        logic                   found;
        logic [63:0]            key;
        logic [SLOT_IDX_W-1:0]  idx;
        logic                   periodic;
    } token_t;

    typedef struct packed {
        reply_kind_t  kind;
        logic [3:0]   handle;
        logic         status;
        logic [63:0]  timeout;
        logic         periodic;
        logic         last;
    } result_t;

endpackage

// ----- rtl/periodic_timer_table.sv -----
// Timer table of NUM_SLOTS slots held in a row of cells. One item is taken at a
// time. A search token walks the cells one per cycle; insert and query each take
// one token pass, while erase takes none. A run takes a shift step and a token
// pass to find the earliest due slot; each fired slot then costs a fire step,
// another full pass (skipped after the 16th fire) and an output step, with at
// most 16 fires per run. A run on an empty table, or with no slot due, gives no
// transfer. Output is registered and may stall freely.
module periodic_timer_table #(
    parameter int NUM_SLOTS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // slot_handle[3:0], expiry_ms[67:4], interval_ms[99:68], now_ms[163:100]
    input  logic [167:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // reply_handle[3:0], status[4], timeout_ms[68:5], fired_periodic[69]
    output logic [71:0]  m_axis_tdata,
    // reply_kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import ptt_pkg::*;

    state_t                 state_reg, state_next;
    opcode_t                op_reg, op_next;
    logic [3:0]             handle_reg, handle_next;
    logic [63:0]            expiry_reg, expiry_next;
    logic [31:0]            period_reg, period_next;
    logic [63:0]            now_reg, now_next;
    logic [63:0]            diff_reg, diff_next;
    logic [63:0]            last_run_reg, last_run_next;
    logic [FIRE_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                   has_pend_reg, has_pend_next;
    logic                   busy_reg, busy_next;
    logic [SLOT_IDX_W-1:0]  pick_reg, pick_next;
    logic                   pick_per_reg, pick_per_next;
    result_t                pend_reg, pend_next;
    result_t                out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    cell_cmd_t              cmd;
    token_t                 tok [NUM_SLOTS+1];
    token_t                 tok_head;
    logic [NUM_SLOTS-1:0]   valid_vec;
    logic                   accept;
    logic                   out_free;
    logic                   erase_hit;
    token_t                 tok_end;
    logic [FIRE_CNT_W-1:0]  cnt_inc;
    opcode_t                in_op;

    assign in_op    = opcode_t'(s_axis_tuser);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign tok[0]   = tok_head;
    assign tok_end  = tok[NUM_SLOTS];
    assign cnt_inc  = cnt_reg + FIRE_CNT_W'(1);

    always_comb
    begin
        erase_hit = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (SLOT_IDX_W'(i) == {2'b00, handle_reg} && valid_vec[i])
                erase_hit = 1'b1;
    end

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++)
        begin : g_cell
            ptt_cell #(.IDX(g)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .tok_in  (tok[g]),
                .tok_out (tok[g+1]),
                .valid   (valid_vec[g])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_ERASE: state_next = ST_ERASE;
                        OP_RUN:   state_next = (valid_vec == '0) ? ST_IDLE : ST_SHIFT;
                        default:  state_next = ST_SCAN;
                    endcase
                end
            end
            ST_ERASE: state_next = ST_OUT;
            ST_SHIFT: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (busy_reg && tok_end.live)
                begin
                    if (op_reg != OP_RUN || has_pend_reg)
                        state_next = ST_OUT;
                    else
                        state_next = tok_end.found ? ST_FIRE : ST_IDLE;
                end
            end
            ST_FIRE: state_next = (cnt_inc == FIRE_CNT_W'(MAX_RESULTS)) ? ST_OUT : ST_SCAN;
            ST_OUT:
            begin
                if (out_free)
                    state_next = pend_reg.last ? ST_IDLE : ST_FIRE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        s_axis_tready  = (state_reg == ST_IDLE);
        op_next        = op_reg;
        handle_next    = handle_reg;
        expiry_next    = expiry_reg;
        period_next    = period_reg;
        now_next       = now_reg;
        diff_next      = diff_reg;
        last_run_next  = last_run_reg;
        cnt_next       = cnt_reg;
        has_pend_next  = has_pend_reg;
        busy_next      = busy_reg;
        pick_next      = pick_reg;
        pick_per_next  = pick_per_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        cmd.op     = CELL_IDLE;
        cmd.sel    = pick_reg;
        cmd.expiry = expiry_reg;
        cmd.period = period_reg;
        cmd.now    = now_reg;
        cmd.diff   = diff_reg;

        tok_head      = '0;
        tok_head.key  = '1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = in_op;
                    handle_next = s_axis_tdata[3:0];
                    expiry_next = s_axis_tdata[67:4];
                    period_next = s_axis_tdata[99:68];
                    now_next    = s_axis_tdata[163:100];
                    diff_next   = (s_axis_tdata[163:100] < last_run_reg)
                                  ? last_run_reg - s_axis_tdata[163:100] : 64'd0;
                end
            end
            ST_ERASE:
            begin
                cmd.op    = erase_hit ? CELL_ERASE : CELL_IDLE;
                cmd.sel   = {2'b00, handle_reg};
                pend_next = '{kind: KIND_ERASE, handle: handle_reg, status: !erase_hit,
                              timeout: 64'd0, periodic: 1'b0, last: 1'b1};
            end
            ST_SHIFT:
            begin
                cmd.op        = CELL_SHIFT;
                last_run_next = now_reg;
                cnt_next      = '0;
                has_pend_next = 1'b0;
            end
            ST_SCAN:
            begin
                case (op_reg)
                    OP_INSERT: cmd.op = CELL_INSERT;
                    OP_QUERY:  cmd.op = CELL_MIN;
                    default:   cmd.op = CELL_DUE;
                endcase
                if (!busy_reg)
                begin
                    tok_head.live = 1'b1;
                    busy_next     = 1'b1;
                end
                else if (tok_end.live)
                begin
                    busy_next     = 1'b0;
                    pick_next     = tok_end.idx;
                    pick_per_next = tok_end.periodic;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            pend_next = '{kind: KIND_INSERT,
                                          handle: tok_end.found ? tok_end.idx[3:0] : 4'd0,
                                          status: !tok_end.found, timeout: 64'd0,
                                          periodic: 1'b0, last: 1'b1};
                        end
                        OP_QUERY:
                        begin
                            pend_next = '{kind: KIND_TIMEOUT, handle: 4'd0, status: 1'b0,
                                          timeout: 64'd0, periodic: 1'b0, last: 1'b1};
                            if (!tok_end.found)
                                pend_next.timeout = '1;
                            else if (now_reg < last_run_reg || tok_end.key <= now_reg)
                                pend_next.timeout = 64'd0;
                            else
                                pend_next.timeout = tok_end.key - now_reg;
                        end
                        default:
                        begin
                            pend_next.last = !tok_end.found;
                        end
                    endcase
                end
            end
            ST_FIRE:
            begin
                cmd.op        = CELL_FIRE;
                cmd.sel       = pick_reg;
                cnt_next      = cnt_inc;
                has_pend_next = 1'b1;
                pend_next     = '{kind: KIND_FIRED, handle: pick_reg[3:0], status: 1'b0,
                                  timeout: 64'd0, periodic: pick_per_reg,
                                  last: (cnt_inc == FIRE_CNT_W'(MAX_RESULTS))};
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd.op = CELL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_run_reg  <= 64'd0;
            cnt_reg       <= '0;
            has_pend_reg  <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_run_reg  <= last_run_next;
            cnt_reg       <= cnt_next;
            has_pend_reg  <= has_pend_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        handle_reg   <= handle_next;
        expiry_reg   <= expiry_next;
        period_reg   <= period_next;
        now_reg      <= now_next;
        diff_reg     <= diff_next;
        pick_reg     <= pick_next;
        pick_per_reg <= pick_per_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.periodic, out_reg.timeout, out_reg.status,
                            out_reg.handle};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;

endmodule

// ----- rtl/ptt_cell.sv -----
module ptt_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ptt_pkg::cell_cmd_t cmd,
    input  ptt_pkg::token_t   tok_in,
    output ptt_pkg::token_t   tok_out,
    output logic              valid
);
    import ptt_pkg::*;

    localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(IDX);

    logic        valid_reg, valid_next;
    logic        fired_reg, fired_next;
    logic [63:0] expiry_reg, expiry_next;
    logic [31:0] period_reg, period_next;
    token_t      tok_reg, tok_next;
    logic        take;
    logic [64:0] reload_sum;

    always_comb
    begin
        reload_sum = {1'b0, cmd.now} + {33'd0, period_reg};
        take = 1'b0;
        if (tok_in.live)
        begin
            case (cmd.op)
                CELL_INSERT: take = !valid_reg && !tok_in.found;
                CELL_MIN:    take = valid_reg && (!tok_in.found || expiry_reg < tok_in.key);
                CELL_DUE:    take = valid_reg && !fired_reg && (expiry_reg <= cmd.now)
                                    && (!tok_in.found || expiry_reg < tok_in.key);
                default:     take = 1'b0;
            endcase
        end

        tok_next = tok_in;
        if (take)
        begin
            tok_next.found    = 1'b1;
            tok_next.key      = expiry_reg;
            tok_next.idx      = MY_IDX;
            tok_next.periodic = (period_reg != 32'd0);
        end

        valid_next  = valid_reg;
        fired_next  = fired_reg;
        expiry_next = expiry_reg;
        period_next = period_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (take)
                begin
                    valid_next  = 1'b1;
                    expiry_next = cmd.expiry;
                    period_next = cmd.period;
                end
            end
            CELL_ERASE:
            begin
                if (cmd.sel == MY_IDX)
                    valid_next = 1'b0;
            end
            CELL_SHIFT:
            begin
                fired_next  = 1'b0;
                expiry_next = (expiry_reg > cmd.diff) ? expiry_reg - cmd.diff : 64'd0;
            end
            CELL_FIRE:
            begin
                if (cmd.sel == MY_IDX)
                begin
                    fired_next = 1'b1;
                    if (period_reg != 32'd0)
                        expiry_next = reload_sum[64] ? '1 : reload_sum[63:0];
                    else
                        valid_next = 1'b0;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            fired_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            fired_reg <= fired_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        expiry_reg <= expiry_next;
        period_reg <= period_next;
    end

    assign tok_out = tok_reg;
    assign valid   = valid_reg;

endmodule
